FILE: sv/swld_pkg.sv
// Shared types, constants and helper functions for the stopwatch lap display.
// No dependencies; every other file of the block imports this package.
package swld_pkg;

	// Six BCD digits: hundredth ones at index 0 up to minute tens at index 5.
	localparam int NumDigits = 6;
	localparam int DigitW    = 4;
	localparam int CharW     = 6;

	localparam logic [CharW-1:0] AsciiZero = 6'h30;

	typedef logic [DigitW-1:0] digit_t;

	// Decimal wrap of a digit cell; the seconds tens digit wraps at six.
	localparam digit_t DecModulus = 4'd10;
	localparam digit_t SixModulus = 4'd6;
	localparam int     SecTensIdx = 3;

	// Input opcodes.
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_BUTTONS = 1'b1;

	// Button bit positions.
	localparam int BtnStart = 0;
	localparam int BtnLap   = 1;
	localparam int BtnStop  = 2;
	localparam int BtnReset = 3;

	// Mode codes shown on the result.
	localparam logic [1:0] MODE_RESET = 2'd0;
	localparam logic [1:0] MODE_RUN   = 2'd1;
	localparam logic [1:0] MODE_LAP   = 2'd2;
	localparam logic [1:0] MODE_STOP  = 2'd3;

	// Watch state; the one-hot code doubles as the LED pattern.
	typedef enum logic [3:0] {
		ST_RUN   = 4'b0001,
		ST_LAP   = 4'b0010,
		ST_STOP  = 4'b0100,
		ST_RESET = 4'b1000
	} watch_state_t;

	// Controls broadcast from the mode controller to every digit cell.
	typedef struct packed {
		logic en;
		logic tick;
		logic clear;
		logic capture;
		logic follow;
	} cell_ctl_t;

	// One buffered result.
	typedef struct packed {
		watch_state_t                state;
		logic [NumDigits-1:0][DigitW-1:0] digits;
	} result_t;

	function automatic digit_t digit_modulus(input int idx);
		digit_t m;
		m = (idx == SecTensIdx) ? SixModulus : DecModulus;
		return m;
	endfunction

	function automatic logic [1:0] mode_code(input watch_state_t s);
		logic [1:0] m;
		unique case (s)
			ST_RUN:  m = MODE_RUN;
			ST_LAP:  m = MODE_LAP;
			ST_STOP: m = MODE_STOP;
			default: m = MODE_RESET;
		endcase
		return m;
	endfunction

	function automatic logic [CharW-1:0] digit_char(input digit_t d);
		logic [CharW-1:0] c;
		c = AsciiZero + CharW'(d);
		return c;
	endfunction

endpackage

FILE: sv/swld_digit_cell.sv
// One BCD digit cell of the stopwatch chain: live counter digit and displayed digit.
// Depends on swld_pkg for the digit type and the control struct.
module swld_digit_cell
	import swld_pkg::*;
#(
	parameter digit_t Modulus = DecModulus
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      carry_in,
	output logic      carry_out,
	output digit_t    shown_next
);

	digit_t live_q;
	digit_t shown_q;
	digit_t live_next;
	logic   at_top;

	// Count step: wrap at the modulus and pass the carry to the next cell.
	assign at_top    = (live_q == Modulus - digit_t'(1));
	assign carry_out = carry_in && at_top;

	always_comb begin
		if (ctl.clear) begin
			live_next = '0;
		end else if (carry_in) begin
			live_next = at_top ? '0 : live_q + digit_t'(1);
		end else begin
			live_next = live_q;
		end
	end

	// Displayed digit is cleared, captured, follows the live digit, or holds its value.
	always_comb begin
		if (ctl.clear) begin
			shown_next = '0;
		end else if (ctl.capture || ctl.follow) begin
			shown_next = live_next;
		end else begin
			shown_next = shown_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			shown_q <= '0;
		end else if (ctl.en) begin
			live_q  <= live_next;
			shown_q <= shown_next;
		end
	end

endmodule

FILE: sv/swld_ctrl.sv
// Mode controller: decodes ticks and button samples and drives the digit cells.
// Depends on swld_pkg for the state enum, opcodes and the cell control struct.
module swld_ctrl
	import swld_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_fire,
	input  logic         opcode,
	input  logic [3:0]   buttons,
	output cell_ctl_t    ctl,
	output watch_state_t state_next
);

	watch_state_t state_q;
	logic         is_sample;

	assign is_sample = (opcode == OP_BUTTONS);

	// Button priority: reset, then stop, then lap, then start.
	// An empty sample keeps the current mode.
	always_comb begin
		state_next = state_q;
		if (is_sample) begin
			priority if (buttons[BtnReset]) begin
				state_next = ST_RESET;
			end else if (buttons[BtnStop]) begin
				state_next = ST_STOP;
			end else if (buttons[BtnLap]) begin
				state_next = ST_LAP;
			end else if (buttons[BtnStart]) begin
				state_next = ST_RUN;
			end else begin
				state_next = state_q;
			end
		end
	end

	// Cell controls for the current transaction.
	always_comb begin
		ctl.en      = in_fire;
		ctl.tick    = in_fire && !is_sample && (state_q == ST_RUN || state_q == ST_LAP);
		ctl.clear   = in_fire && is_sample && buttons[BtnReset];
		ctl.capture = in_fire && is_sample && !buttons[BtnReset] && !buttons[BtnStop]
			&& buttons[BtnLap];
		ctl.follow  = in_fire && (state_next == ST_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RESET;
		end else if (in_fire) begin
			state_q <= state_next;
		end
	end

endmodule

FILE: sv/stopwatch_lap_display.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  opcode, buttons
// out      out_valid / out_stall mode, led_pattern, six ASCII digit characters
//
// Each transaction updates the mode and the digit chain in the cycle it is accepted;
// its result is registered in the output or skid register. One item per cycle while in_stall is low.
// The carry ripples through the six digit cells within that cycle.
// A two-entry output buffer (output register plus skid register) absorbs stalls;
// in_stall rises only when both entries hold results.
// Reset clears the mode to reset, all digits to zero and empties the buffer.
// Top level of the stopwatch lap display; depends on swld_pkg, swld_ctrl, swld_digit_cell.
module stopwatch_lap_display
	import swld_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             opcode,
	input  logic [3:0]       buttons,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       mode,
	output logic [3:0]       led_pattern,
	output logic [CharW-1:0] minute_tens_char,
	output logic [CharW-1:0] minute_ones_char,
	output logic [CharW-1:0] second_tens_char,
	output logic [CharW-1:0] second_ones_char,
	output logic [CharW-1:0] hundredth_tens_char,
	output logic [CharW-1:0] hundredth_ones_char
);

	logic         in_fire;
	logic         out_fire;
	logic         out_free;
	cell_ctl_t    ctl;
	watch_state_t state_next;
	logic [NumDigits:0] carry;
	logic [NumDigits-1:0][DigitW-1:0] shown_next;
	result_t      result_new;
	result_t      out_q;
	result_t      skid_q;
	logic         out_valid_q;
	logic         skid_valid_q;

	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !skid_valid_q;
	assign out_fire = out_valid_q && !out_stall;
	assign out_free = out_fire || !out_valid_q;

	swld_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.opcode     (opcode),
		.buttons    (buttons),
		.ctl        (ctl),
		.state_next (state_next)
	);

	// Chain of digit cells, carry handed from the hundredth ones upward.
	assign carry[0] = ctl.tick;

	for (genvar i = 0; i < NumDigits; i++) begin : g_cell
		swld_digit_cell #(
			.Modulus (digit_modulus(i))
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.carry_in   (carry[i]),
			.carry_out  (carry[i+1]),
			.shown_next (shown_next[i])
		);
	end

	assign result_new.state  = state_next;
	assign result_new.digits = shown_next;

	// Output buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || in_fire;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Output buffer payload.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= result_new;
			end
		end else if (in_fire) begin
			skid_q <= result_new;
		end
	end

	// Result formatting from the output register.
	assign out_valid           = out_valid_q;
	assign mode                = mode_code(out_q.state);
	assign led_pattern         = out_q.state;
	assign minute_tens_char    = digit_char(out_q.digits[5]);
	assign minute_ones_char    = digit_char(out_q.digits[4]);
	assign second_tens_char    = digit_char(out_q.digits[3]);
	assign second_ones_char    = digit_char(out_q.digits[2]);
	assign hundredth_tens_char = digit_char(out_q.digits[1]);
	assign hundredth_ones_char = digit_char(out_q.digits[0]);

endmodule

FILE: sv/swld_checker.sv
// Port-level checks for the stopwatch lap display, attached to the top level by bind.
// Depends on swld_pkg for mode codes and the character width.
module swld_checker
	import swld_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [1:0]       mode,
	input logic [3:0]       led_pattern,
	input logic [CharW-1:0] minute_tens_char,
	input logic [CharW-1:0] minute_ones_char,
	input logic [CharW-1:0] second_tens_char,
	input logic [CharW-1:0] second_ones_char,
	input logic [CharW-1:0] hundredth_tens_char,
	input logic [CharW-1:0] hundredth_ones_char
);

	// The LED pattern of a result is one-hot.
	a_led_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(led_pattern))
		else $error("led_pattern is not one-hot");

	// The LED pattern agrees with the reported mode.
	a_led_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((mode == MODE_RUN && led_pattern == 4'd1)
			|| (mode == MODE_LAP && led_pattern == 4'd2)
			|| (mode == MODE_STOP && led_pattern == 4'd4)
			|| (mode == MODE_RESET && led_pattern == 4'd8)))
		else $error("led_pattern does not match mode");

	// In reset mode every displayed digit reads zero.
	a_reset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mode == MODE_RESET) |-> (minute_tens_char == AsciiZero
			&& minute_ones_char == AsciiZero && second_tens_char == AsciiZero
			&& second_ones_char == AsciiZero && hundredth_tens_char == AsciiZero
			&& hundredth_ones_char == AsciiZero))
		else $error("digits not zero in reset mode");

	// The input side stalls only while a result is pending at the output.
	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// A transaction accepted into an empty block yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_valid) |=> out_valid)
		else $error("accepted transaction produced no result");

endmodule

bind stopwatch_lap_display swld_checker u_swld_checker (.*);
